[design/quadratic_root_finder_assert.svh]
// Assertion macros used by the port-level checker file.
`ifndef QUADRATIC_ROOT_FINDER_ASSERT_SVH
`define QUADRATIC_ROOT_FINDER_ASSERT_SVH
`define QRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/qrf_pkg.sv]
// Package with the types and codes of the quadratic root finder.
package qrf_pkg;
  typedef enum logic [1:0] {
    MODE_NEWTON = 2'd0,
    MODE_SECANT = 2'd1,
    MODE_BISECT = 2'd2,
    MODE_FALSE  = 2'd3
  } mode_t;
  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_NO_CONV   = 2'd1,
    ST_DIV_ZERO  = 2'd2
  } status_t;
  typedef enum logic {
    REG_PRECISION = 1'b0,
    REG_MAX_ITER  = 1'b1
  } reg_idx_t;
  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1
  } alu_op_t;
  typedef enum logic [4:0] {
    S_IDLE, S_LOOP, S_F_AX, S_F_AXX, S_F_BX, S_F_SUM,
    S_N_D, S_N_DIV, S_N_STEP,
    S_S_MUL, S_S_DIV, S_S_STEP,
    S_P_M1, S_P_M2, S_P_DIV, S_B_EVAL, S_B_TEST,
    S_DONE
  } state_t;
endpackage

[design/quadratic_root_finder.sv]
// Top level of the iterative quadratic root finder.
// Each iteration runs its multiply and, where its mode needs them, divide passes one at a
// time on the shared ALU; the result strobe is raised from S_DONE after the last iteration.
// Throughput: one request at a time; busy stays high until the result strobe, which the
// receiver cannot stall. Reset: synchronous active-low; precision 1, max_iterations 100.
module quadratic_root_finder #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_coef_a,
  input  logic signed [31:0] in_coef_b,
  input  logic signed [31:0] in_coef_c,
  input  logic signed [31:0] in_guess_first,
  input  logic signed [31:0] in_guess_second,
  output logic               out_valid,
  output logic signed [31:0] out_root,
  output logic [1:0]         out_status,
  output logic [7:0]         out_iterations_left,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import qrf_pkg::*;
  localparam int W = WORD_BITS;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] p,
                                                input logic signed [W-1:0] q);
    logic signed [W:0] s;
    s = {p[W-1], p} + {q[W-1], q};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction
  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] p,
                                                input logic signed [W-1:0] q);
    logic signed [W:0] s;
    s = {p[W-1], p} - {q[W-1], q};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction
  function automatic logic signed [W-1:0] load(input logic signed [31:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'(WMAX)) return WMAX;
    if (e < 64'(WMIN)) return WMIN;
    return W'(e);
  endfunction
  function automatic logic signed [31:0] clip32(input logic signed [W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'sd2147483647) return 32'sh7fffffff;
    if (e < -64'sd2147483648) return 32'sh80000000;
    return 32'(e);
  endfunction

  logic [15:0] prec_r;
  logic [7:0]  maxit_r;
  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic signed [W-1:0] a_r, b_r, c_r, x1_r, x2_r, x3_r, f1_r, f2_r, f3_r;
  logic signed [W-1:0] a_nxt, b_nxt, c_nxt, x1_nxt, x2_nxt, x3_nxt;
  logic signed [W-1:0] f1_nxt, f2_nxt, f3_nxt;
  logic signed [W-1:0] t_r, t_nxt, u_r, u_nxt, fx_r, fx_nxt, fres_r, fres_nxt;
  logic [1:0] fsel_r, fsel_nxt;
  logic [7:0] it_r, it_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic signed [31:0] oroot_r, oroot_nxt;
  logic [1:0] ostat_r, ostat_nxt;
  logic [7:0] oleft_r, oleft_nxt;
  logic       pend_r, pend_nxt;

  logic alu_go, alu_done;
  alu_op_t alu_op;
  logic signed [W-1:0] alu_a, alu_b, alu_res;
  logic signed [W-1:0] mid, stp, dd, fsum;
  logic [W-1:0] sm;

  qrf_alu #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst_n(rst_n), .go(alu_go), .op(alu_op), .opa(alu_a), .opb(alu_b),
    .done(alu_done), .res(alu_res)
  );

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r  <= 16'd1;
      maxit_r <= 8'd100;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PRECISION: prec_r  <= cfg_data;
        REG_MAX_ITER:  maxit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign mid = W'(({x1_r[W-1], x1_r} + {x2_r[W-1], x2_r}) >>> 1);

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    x1_nxt = x1_r; x2_nxt = x2_r; x3_nxt = x3_r;
    f1_nxt = f1_r; f2_nxt = f2_r; f3_nxt = f3_r;
    t_nxt = t_r; u_nxt = u_r; fx_nxt = fx_r; fres_nxt = fres_r; fsel_nxt = fsel_r;
    it_nxt = it_r; ovalid_nxt = 1'b0; oroot_nxt = oroot_r; ostat_nxt = ostat_r;
    oleft_nxt = oleft_r; pend_nxt = 1'b0;
    alu_go = 1'b0; alu_op = ALU_MUL; alu_a = '0; alu_b = '0;
    stp = '0; sm = '0; dd = '0; fsum = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = mode_t'(in_mode);
          a_nxt = load(in_coef_a); b_nxt = load(in_coef_b); c_nxt = load(in_coef_c);
          x1_nxt = load(in_guess_first); x2_nxt = load(in_guess_second);
          it_nxt = maxit_r;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (it_r == 8'd0) begin
          ostat_nxt = ST_NO_CONV; oroot_nxt = '0; oleft_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          fx_nxt = x1_r; fsel_nxt = 2'd1;
          state_nxt = S_F_AX; pend_nxt = 1'b1;
        end
      end
      S_F_AX: begin
        alu_go = pend_r; alu_a = a_r; alu_b = fx_r;
        if (alu_done) begin
          u_nxt = alu_res; state_nxt = S_F_AXX; pend_nxt = 1'b1;
        end
      end
      S_F_AXX: begin
        alu_go = pend_r; alu_a = u_r; alu_b = fx_r;
        if (alu_done) begin
          fres_nxt = alu_res; state_nxt = S_F_BX; pend_nxt = 1'b1;
        end
      end
      S_F_BX: begin
        alu_go = pend_r; alu_a = b_r; alu_b = fx_r;
        if (alu_done) begin
          fres_nxt = sadd(fres_r, alu_res); state_nxt = S_F_SUM;
        end
      end
      S_F_SUM: begin
        fsum = sadd(fres_r, c_r);
        pend_nxt = 1'b1;
        if (fsel_r == 2'd1) begin
          f1_nxt = fsum;
          if (mode_r == MODE_NEWTON) begin
            t_nxt = u_r; state_nxt = S_N_D;
          end else begin
            fx_nxt = x2_r; fsel_nxt = 2'd2; state_nxt = S_F_AX;
          end
        end else if (fsel_r == 2'd2) begin
          f2_nxt = fsum;
          if (mode_r == MODE_BISECT) begin
            x3_nxt = mid; fx_nxt = mid; fsel_nxt = 2'd3; state_nxt = S_F_AX;
          end else if (fsum == f1_r) begin
            ostat_nxt = ST_DIV_ZERO; oroot_nxt = '0; oleft_nxt = '0; state_nxt = S_DONE;
          end else if (mode_r == MODE_SECANT) begin
            state_nxt = S_S_MUL;
          end else begin
            state_nxt = S_P_M1;
          end
        end else begin
          f3_nxt = fsum; state_nxt = S_B_TEST;
        end
      end
      S_N_D: begin
        dd = sadd(sadd(t_r, t_r), b_r);
        if (dd == '0) begin
          ostat_nxt = ST_DIV_ZERO; oroot_nxt = '0; oleft_nxt = '0; state_nxt = S_DONE;
        end else begin
          t_nxt = dd; state_nxt = S_N_DIV; pend_nxt = 1'b1;
        end
      end
      S_N_DIV: begin
        alu_go = pend_r; alu_op = ALU_DIV; alu_a = f1_r; alu_b = t_r;
        if (alu_done) begin
          x3_nxt = ssub(x1_r, alu_res); state_nxt = S_N_STEP;
        end
      end
      S_N_STEP, S_S_STEP: begin
        stp = ssub(x3_r, (state_r == S_N_STEP) ? x1_r : x2_r);
        sm = stp[W-1] ? W'(-stp) : W'(stp);
        if (sm < W'(prec_r)) begin
          ostat_nxt = ST_CONVERGED; oleft_nxt = it_r;
          oroot_nxt = clip32(x3_r); state_nxt = S_DONE;
        end else begin
          if (state_r == S_N_STEP) x1_nxt = x3_r;
          else begin
            x1_nxt = x2_r; x2_nxt = x3_r;
          end
          it_nxt = it_r - 8'd1; state_nxt = S_LOOP;
        end
      end
      S_S_MUL: begin
        alu_go = pend_r; alu_a = f2_r; alu_b = ssub(x2_r, x1_r);
        if (alu_done) begin
          u_nxt = alu_res; state_nxt = S_S_DIV; pend_nxt = 1'b1;
        end
      end
      S_S_DIV: begin
        alu_go = pend_r; alu_op = ALU_DIV; alu_a = u_r; alu_b = ssub(f2_r, f1_r);
        if (alu_done) begin
          x3_nxt = ssub(x2_r, alu_res); state_nxt = S_S_STEP;
        end
      end
      S_P_M1: begin
        alu_go = pend_r; alu_a = x1_r; alu_b = f2_r;
        if (alu_done) begin
          u_nxt = alu_res; state_nxt = S_P_M2; pend_nxt = 1'b1;
        end
      end
      S_P_M2: begin
        alu_go = pend_r; alu_a = x2_r; alu_b = f1_r;
        if (alu_done) begin
          u_nxt = ssub(u_r, alu_res); state_nxt = S_P_DIV; pend_nxt = 1'b1;
        end
      end
      S_P_DIV: begin
        alu_go = pend_r; alu_op = ALU_DIV; alu_a = u_r; alu_b = ssub(f2_r, f1_r);
        if (alu_done) begin
          x3_nxt = alu_res; fx_nxt = alu_res; fsel_nxt = 2'd3;
          state_nxt = S_F_AX; pend_nxt = 1'b1;
        end
      end
      S_B_EVAL: state_nxt = S_B_TEST;
      S_B_TEST: begin
        stp = ssub(x3_r, x2_r);
        sm = stp[W-1] ? W'(-stp) : W'(stp);
        if (f3_r == '0 || sm < W'(prec_r)) begin
          ostat_nxt = ST_CONVERGED; oleft_nxt = it_r; state_nxt = S_DONE;
          oroot_nxt = clip32(x3_r);
        end else begin
          if ((f1_r < 0 && f3_r > 0) || (f1_r > 0 && f3_r < 0)) x2_nxt = x3_r;
          else x1_nxt = x3_r;
          it_nxt = it_r - 8'd1; state_nxt = S_LOOP;
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r   <= pend_nxt;
    end
    mode_r <= mode_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
    x1_r <= x1_nxt; x2_r <= x2_nxt; x3_r <= x3_nxt;
    f1_r <= f1_nxt; f2_r <= f2_nxt; f3_r <= f3_nxt;
    t_r <= t_nxt; u_r <= u_nxt; fx_r <= fx_nxt; fres_r <= fres_nxt; fsel_r <= fsel_nxt;
    it_r <= it_nxt; oroot_r <= oroot_nxt; ostat_r <= ostat_nxt; oleft_r <= oleft_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_root = oroot_r;
  assign out_status = ostat_r;
  assign out_iterations_left = oleft_r;
endmodule

[design/qrf_alu.sv]
// Shared multi-cycle fixed-point multiplier and divider with saturation.
module qrf_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  qrf_pkg::alu_op_t            op,
  input  logic signed [WORD_BITS-1:0] opa,
  input  logic signed [WORD_BITS-1:0] opb,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res
);
  import qrf_pkg::*;
  localparam int W2 = 2 * WORD_BITS;
  localparam int CW = $clog2(W2 + 1);
  localparam logic [W2-1:0] MAXM = W2'({1'b0, {(WORD_BITS-1){1'b1}}});

  logic              busy_r, busy_nxt;
  alu_op_t           op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [W2-1:0]     acc_r, acc_nxt;
  logic [W2-1:0]     sh_r, sh_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS:0]   rem_r, rem_nxt;
  logic              done_r, done_nxt;
  logic signed [WORD_BITS-1:0] res_r, res_nxt;

  logic [WORD_BITS-1:0] ma, mb;
  logic [W2-1:0]        mag, shifted;
  logic [WORD_BITS:0]   rtry;

  assign ma = opa[WORD_BITS-1] ? WORD_BITS'(-opa) : WORD_BITS'(opa);
  assign mb = opb[WORD_BITS-1] ? WORD_BITS'(-opb) : WORD_BITS'(opb);

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    mag      = '0;
    shifted  = '0;
    rtry     = '0;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        op_nxt   = op;
        neg_nxt  = opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
        cnt_nxt  = CW'(W2);
        acc_nxt  = '0;
        rem_nxt  = '0;
        b_nxt    = mb;
        if (op == ALU_MUL) begin
          sh_nxt  = W2'(ma);
          cnt_nxt = CW'(WORD_BITS);
        end else begin
          sh_nxt = W2'(ma) << FRAC_BITS;
        end
      end
    end else if (op_r == ALU_MUL) begin
      if (b_r[0]) acc_nxt = acc_r + sh_r;
      sh_nxt  = sh_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      rtry    = {rem_r[WORD_BITS-1:0], sh_r[W2-1]};
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (rtry >= {1'b0, b_r}) begin
        rem_nxt = rtry - {1'b0, b_r};
        acc_nxt = {acc_r[W2-2:0], 1'b1};
      end else begin
        rem_nxt = rtry;
        acc_nxt = {acc_r[W2-2:0], 1'b0};
      end
    end
    if (busy_r && cnt_r == CW'(1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
      if (op_r == ALU_MUL) begin
        shifted = (b_r[0] ? acc_r + sh_r : acc_r) >> FRAC_BITS;
        mag     = shifted;
      end else begin
        mag = acc_nxt;
      end
      if (!neg_r) res_nxt = (mag > MAXM) ? WORD_BITS'(MAXM) : WORD_BITS'(mag);
      else res_nxt = (mag > MAXM) ? WORD_BITS'(~MAXM) : WORD_BITS'(-mag);
      if (op_r == ALU_DIV && b_r == '0) res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

[design/qrf_checker.sv]
// Port-level checker for the quadratic root finder, bound to the top level.
`include "quadratic_root_finder_assert.svh"
module qrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [31:0] out_root,
  input logic [7:0] out_iterations_left
);
  import qrf_pkg::*;
  `QRF_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `QRF_ASSERT_IMPL(a_done_idle, out_valid, !busy)
  `QRF_ASSERT_NEXT(a_done_pulse, out_valid, !out_valid)
  `QRF_ASSERT_IMPL(a_status_ok, out_valid, out_status != 2'd3)
  `QRF_ASSERT_IMPL(a_fail_zero, out_valid && out_status != ST_CONVERGED,
                   out_root == '0 && out_iterations_left == '0)
endmodule

bind quadratic_root_finder qrf_checker u_qrf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_root(out_root), .out_iterations_left(out_iterations_left)
);
